>>> rtl/core/sac_pkg.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer package
// Shared types, key codes and sizes for the capitalizer core and its stages.
// ----------------------------------------------------------------------------
package sac_pkg;

	localparam int HIST_DEPTH = 6;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_INIT   = 3'd0,
		PH_WORD   = 3'd1,
		PH_ABBR   = 3'd2,
		PH_END    = 3'd3,
		PH_PRIMED = 3'd4
	} phase_t;

	localparam logic        OP_KEY    = 1'b0;
	localparam logic        OP_TOGGLE = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] KEY_PAGE      = 16'h0007;
	localparam logic [7:0]  SHIFT_BITS    = 8'h22;

	localparam logic [7:0]  KC_A         = 8'h04;
	localparam logic [7:0]  KC_Z         = 8'h1D;
	localparam logic [7:0]  KC_1         = 8'h1E;
	localparam logic [7:0]  KC_0         = 8'h27;
	localparam logic [7:0]  KC_BKSP      = 8'h2A;
	localparam logic [7:0]  KC_SPACE     = 8'h2C;
	localparam logic [7:0]  KC_APOS      = 8'h34;
	localparam logic [7:0]  KC_DOT       = 8'h37;
	localparam logic [7:0]  KC_SLASH     = 8'h38;
	localparam logic [7:0]  KC_MOD_FIRST = 8'hE0;
	localparam logic [7:0]  KC_MOD_LAST  = 8'hE7;
	localparam logic [7:0]  KC_LSHIFT    = 8'hE1;
	localparam logic [7:0]  KC_RSHIFT    = 8'hE5;

	typedef struct packed {
		logic        op;
		logic        pressed;
		logic [15:0] hid_page;
		logic [7:0]  key_code;
		logic [31:0] time_ms;
		logic [7:0]  implicit_mods;
		logic [7:0]  explicit_mods;
	} evt_t;

	typedef struct packed {
		logic       add_shift;
		logic       mask_shift_set;
		logic       mask_shift_clear;
		logic       armed;
		logic       disarmed;
		logic       notify;
		logic [2:0] phase;
	} res_t;

endpackage

>>> rtl/core/sac_in_stage.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer input stage
// Registers one key event and holds it until the core can take it.
// ----------------------------------------------------------------------------
module sac_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sac_pkg::evt_t evt_in,
	input  logic          adv,
	output logic          valid_s1,
	output sac_pkg::evt_t evt_s1
);

	logic take;

	assign in_stall = valid_s1 & ~adv;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1 <= evt_in;
		end
	end

endmodule

>>> rtl/core/sac_core.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer core
// Holds the sentence state and computes one event's update and result.
// ----------------------------------------------------------------------------
module sac_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	input  logic          go,
	input  sac_pkg::evt_t e,
	output sac_pkg::res_t res
);

	logic                       en_q, en_d;
	sac_pkg::phase_t            ph_q, ph_d;
	logic                       opt_q, opt_d;
	logic [sac_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	sac_pkg::phase_t            hist_q [sac_pkg::HIST_DEPTH];
	sac_pkg::phase_t            hist_d [sac_pkg::HIST_DEPTH];
	logic                       mact_q, mact_d;
	logic [15:0]                mpage_q, mpage_d;
	logic [7:0]                 mcode_q, mcode_d;
	logic [31:0]                last_q, last_d;
	logic                       parm_q, parm_d;
	logic                       popt_q, popt_d;
	logic [15:0]                tmo_q;

	logic [7:0]                 mods;
	logic                       kp, shifted, is_alpha, is_ending, is_digit, is_mod;
	logic [31:0]                gap;
	logic                       tmo_hit;
	sac_pkg::phase_t            ph_a;
	logic                       opt_a, pa_a, po_a;
	logic [sac_pkg::CNT_W-1:0]  cnt_a;
	logic                       known;
	sac_pkg::phase_t            nxt;
	logic                       call2, opt_b, arm_b, note;
	sac_pkg::phase_t            ph_b;
	logic                       add, mset, mclr;

	assign mods      = e.implicit_mods | e.explicit_mods;
	assign kp        = e.hid_page == sac_pkg::KEY_PAGE;
	assign shifted   = (mods & sac_pkg::SHIFT_BITS) != 8'd0;
	assign is_alpha  = e.key_code >= sac_pkg::KC_A && e.key_code <= sac_pkg::KC_Z;
	assign is_digit  = e.key_code >= sac_pkg::KC_1 && e.key_code <= sac_pkg::KC_0;
	assign is_mod    = e.key_code >= sac_pkg::KC_MOD_FIRST && e.key_code <= sac_pkg::KC_MOD_LAST;
	assign is_ending = (e.key_code == sac_pkg::KC_DOT && !shifted) ||
	                   (e.key_code == sac_pkg::KC_SLASH && shifted) ||
	                   (e.key_code == sac_pkg::KC_1 && shifted);

	// An idle gap beyond the timeout clears the phase before the key is applied.
	assign gap     = e.time_ms - last_q;
	assign tmo_hit = (last_q != 32'd0) && (gap > {16'd0, tmo_q});
	assign ph_a    = tmo_hit ? sac_pkg::PH_INIT : ph_q;
	assign opt_a   = tmo_hit ? 1'b0 : opt_q;
	assign cnt_a   = tmo_hit ? '0 : cnt_q;
	assign pa_a    = tmo_hit ? 1'b0 : parm_q;
	assign po_a    = tmo_hit ? 1'b0 : popt_q;

	always_comb begin
		known = 1'b1;
		nxt   = sac_pkg::PH_INIT;
		if (kp && e.key_code == sac_pkg::KC_APOS) begin
			nxt = ph_a;
		end else if (kp && is_alpha) begin
			nxt = (ph_a == sac_pkg::PH_END || ph_a == sac_pkg::PH_ABBR) ?
			      sac_pkg::PH_ABBR : sac_pkg::PH_WORD;
		end else if (kp && e.key_code == sac_pkg::KC_SPACE) begin
			nxt = (ph_a == sac_pkg::PH_END || ph_a == sac_pkg::PH_PRIMED) ?
			      sac_pkg::PH_PRIMED : sac_pkg::PH_INIT;
		end else if (kp && is_ending) begin
			nxt = (ph_a == sac_pkg::PH_WORD || ph_a == sac_pkg::PH_END) ?
			      sac_pkg::PH_END : sac_pkg::PH_ABBR;
		end else if (kp && is_digit) begin
			nxt = sac_pkg::PH_WORD;
		end else begin
			known = 1'b0;
		end
	end

	always_comb begin
		en_d    = en_q;
		ph_d    = ph_q;
		opt_d   = opt_q;
		cnt_d   = cnt_q;
		hist_d  = hist_q;
		mact_d  = mact_q;
		mpage_d = mpage_q;
		mcode_d = mcode_q;
		last_d  = last_q;
		parm_d  = parm_q;
		popt_d  = popt_q;
		add     = 1'b0;
		mset    = 1'b0;
		mclr    = 1'b0;
		note    = 1'b0;
		call2   = 1'b0;
		ph_b    = ph_a;
		opt_b   = opt_a;
		arm_b   = 1'b0;
		case (e.op)
			sac_pkg::OP_TOGGLE: begin
				en_d   = ~en_q;
				ph_d   = sac_pkg::PH_INIT;
				opt_d  = 1'b0;
				cnt_d  = '0;
				last_d = 32'd0;
				note   = parm_q | popt_q;
				parm_d = 1'b0;
				popt_d = 1'b0;
			end
			default: begin
				if (en_q && !e.pressed) begin
					if (mact_q && e.hid_page == mpage_q && e.key_code == mcode_q) begin
						mact_d = 1'b0;
						mclr   = 1'b1;
					end
				end else if (en_q) begin
					last_d = e.time_ms;
					cnt_d  = cnt_a;
					if (kp && is_mod) begin
						if (ph_a == sac_pkg::PH_PRIMED &&
						    (e.key_code == sac_pkg::KC_LSHIFT ||
						     e.key_code == sac_pkg::KC_RSHIFT)) begin
							opt_b = 1'b1;
							call2 = 1'b1;
						end
					end else if (kp && e.key_code == sac_pkg::KC_BKSP) begin
						call2 = 1'b1;
						if (cnt_a == '0) begin
							ph_b = sac_pkg::PH_INIT;
						end else begin
							ph_b = hist_q[0];
							for (int i = 0; i < sac_pkg::HIST_DEPTH - 1; i++) begin
								hist_d[i] = hist_q[i + 1];
							end
							cnt_d = cnt_a - sac_pkg::CNT_W'(1);
						end
					end else if ((mods & ~sac_pkg::SHIFT_BITS) != 8'd0 || !known) begin
						call2 = 1'b1;
						ph_b  = sac_pkg::PH_INIT;
						cnt_d = '0;
					end else begin
						if (kp && is_alpha && ph_a == sac_pkg::PH_PRIMED) begin
							if (opt_a && shifted) begin
								mset    = 1'b1;
								mact_d  = 1'b1;
								mpage_d = e.hid_page;
								mcode_d = e.key_code;
							end else if (!opt_a && !shifted) begin
								add = 1'b1;
							end
						end
						if (cnt_a < sac_pkg::CNT_W'(sac_pkg::HIST_DEPTH)) begin
							cnt_d = cnt_a + sac_pkg::CNT_W'(1);
						end
						for (int i = 1; i < sac_pkg::HIST_DEPTH; i++) begin
							hist_d[i] = hist_q[i - 1];
						end
						hist_d[0] = ph_a;
						call2     = 1'b1;
						ph_b      = nxt;
					end
					// The disarm flag only lives while the machine is primed.
					if (ph_b != sac_pkg::PH_PRIMED) begin
						opt_b = 1'b0;
					end
					arm_b  = ph_b == sac_pkg::PH_PRIMED && !opt_b;
					ph_d   = ph_b;
					opt_d  = opt_b;
					note   = (tmo_hit && (parm_q || popt_q)) ||
					         (call2 && (arm_b != pa_a || opt_b != po_a));
					parm_d = call2 ? arm_b : pa_a;
					popt_d = call2 ? opt_b : po_a;
				end
			end
		endcase
	end

	assign res.add_shift        = add;
	assign res.mask_shift_set   = mset;
	assign res.mask_shift_clear = mclr;
	assign res.armed            = en_d && ph_d == sac_pkg::PH_PRIMED && !opt_d;
	assign res.disarmed         = opt_d;
	assign res.notify           = note;
	assign res.phase            = ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= sac_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			tmo_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			ph_q    <= sac_pkg::PH_INIT;
			opt_q   <= 1'b0;
			cnt_q   <= '0;
			mact_q  <= 1'b0;
			mpage_q <= 16'd0;
			mcode_q <= 8'd0;
			last_q  <= 32'd0;
			parm_q  <= 1'b0;
			popt_q  <= 1'b0;
		end else if (go) begin
			en_q    <= en_d;
			ph_q    <= ph_d;
			opt_q   <= opt_d;
			cnt_q   <= cnt_d;
			mact_q  <= mact_d;
			mpage_q <= mpage_d;
			mcode_q <= mcode_d;
			last_q  <= last_d;
			parm_q  <= parm_d;
			popt_q  <= popt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hist_q <= hist_d;
		end
	end

endmodule

>>> rtl/core/sac_out_stage.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer output stage
// Result register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sac_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  sac_pkg::res_t res_in,
	output logic          adv,
	output logic          out_valid,
	input  logic          out_stall,
	output sac_pkg::res_t res_q
);

	assign adv = valid_s1 & (~out_valid | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_in;
		end
	end

endmodule

>>> rtl/core/sentence_auto_capitalizer_top.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer top level
// Keyboard event filter that decides when to capitalize the next letter.
// ----------------------------------------------------------------------------
// The block accepts one keyboard event per clock cycle while the output is not
// stalled, and returns exactly one result per event after the event has passed
// through the input register and then the result register. The rate of one
// event per cycle is set by the combinational update of the sentence state
// (phase, undo history, disarm flag, shift mask and timestamp), which the core
// commits as each event moves from the input register to the result register.
// The timeout register is written through cfg_wr_en and cfg_wr_data
// and should only be changed while no event is in flight.
module sentence_auto_capitalizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic        pressed,
	input  logic [15:0] hid_page,
	input  logic [7:0]  key_code,
	input  logic [31:0] time_ms,
	input  logic [7:0]  implicit_mods,
	input  logic [7:0]  explicit_mods,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        add_shift,
	output logic        mask_shift_set,
	output logic        mask_shift_clear,
	output logic        armed,
	output logic        disarmed,
	output logic        notify,
	output logic [2:0]  phase
);

	sac_pkg::evt_t evt_in, evt_s1;
	sac_pkg::res_t res_d, res_q;
	logic          valid_s1, adv;

	// Gather the event fields into one word for the input register.
	assign evt_in.op            = op;
	assign evt_in.pressed       = pressed;
	assign evt_in.hid_page      = hid_page;
	assign evt_in.key_code      = key_code;
	assign evt_in.time_ms       = time_ms;
	assign evt_in.implicit_mods = implicit_mods;
	assign evt_in.explicit_mods = explicit_mods;

	sac_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.evt_in   (evt_in),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.evt_s1   (evt_s1)
	);

	// The core commits its state exactly when the event moves into the
	// result register, so a stalled output freezes the sentence state too.
	sac_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.go          (adv),
		.e           (evt_s1),
		.res         (res_d)
	);

	sac_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_in    (res_d),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign add_shift        = res_q.add_shift;
	assign mask_shift_set   = res_q.mask_shift_set;
	assign mask_shift_clear = res_q.mask_shift_clear;
	assign armed            = res_q.armed;
	assign disarmed         = res_q.disarmed;
	assign notify           = res_q.notify;
	assign phase            = res_q.phase;

endmodule

>>> tb/sentence_auto_capitalizer_top_tb.sv
// ----------------------------------------------------------------------------
// Sentence auto-capitalizer top level testbench
// Sends keyboard events to the capitalizer with random idle cycles and output
// stalls. A copy of the sentence machine in the testbench predicts each
// result, and every result the block returns is checked against it. The
// timeout register is reprogrammed between phases, and each phase mixes
// well-formed sentences with noise.
// ----------------------------------------------------------------------------
module sentence_auto_capitalizer_top_tb;

	import sac_pkg::*;

	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;

	// Clock, reset and the block's inputs all start at known values.
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        in_valid    = 1'b0;
	logic        out_stall   = 1'b0;
	evt_t        drv         = '0;

	logic        in_stall;
	logic        out_valid;
	logic        add_shift;
	logic        mask_shift_set;
	logic        mask_shift_clear;
	logic        armed;
	logic        disarmed;
	logic        notify;
	logic [2:0]  phase;

	sentence_auto_capitalizer_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (drv.op),
		.pressed          (drv.pressed),
		.hid_page         (drv.hid_page),
		.key_code         (drv.key_code),
		.time_ms          (drv.time_ms),
		.implicit_mods    (drv.implicit_mods),
		.explicit_mods    (drv.explicit_mods),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.add_shift        (add_shift),
		.mask_shift_set   (mask_shift_set),
		.mask_shift_clear (mask_shift_clear),
		.armed            (armed),
		.disarmed         (disarmed),
		.notify           (notify),
		.phase            (phase)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Events waiting to be driven, and the results still owed by the block.
	evt_t event_backlog[$];
	res_t expected_verdicts[$];

	int errors     = 0;
	int result_no  = 0;
	int n_items    = 0;
	int cyc        = 0;
	int calm_left  = 0;

	// ------------------------------------------------------------------------
	// Predicted sentence state. It mirrors the block from reset onward and is
	// advanced once for every event transfer into the block.
	// ------------------------------------------------------------------------
	logic        cap_enabled   = 1'b1;
	phase_t      cur_phase     = PH_INIT;
	phase_t      undo_hist[HIST_DEPTH];
	int          undo_count    = 0;
	logic        opted         = 1'b0;
	logic        mask_on       = 1'b0;
	logic [15:0] mask_pg       = 16'd0;
	logic [7:0]  mask_kc       = 8'd0;
	logic [31:0] last_stamp    = 32'd0;
	logic        shown_armed   = 1'b0;
	logic        shown_opted   = 1'b0;
	logic        state_changed = 1'b0;
	logic [15:0] timeout_reg   = TIMEOUT_RESET;

	initial begin
		foreach (undo_hist[i]) undo_hist[i] = PH_INIT;
	end

	function automatic logic is_armed();
		return cap_enabled && cur_phase == PH_PRIMED && !opted;
	endfunction

	// Moves to a new phase. Leaving the primed phase drops the opt-out, and any
	// change of the armed or opted-out pair raises the change notice.
	function automatic void enter_phase(phase_t p);
		logic a;
		cur_phase = p;
		if (p != PH_PRIMED) opted = 1'b0;
		a = is_armed();
		if (a != shown_armed || opted != shown_opted) begin
			shown_armed   = a;
			shown_opted   = opted;
			state_changed = 1'b1;
		end
	endfunction

	function automatic void reset_sentence();
		enter_phase(PH_INIT);
		undo_count = 0;
	endfunction

	function automatic res_t capitalize_decision(evt_t e);
		res_t        r;
		logic [7:0]  mods;
		logic        kp;
		logic        shf;
		logic        known;
		logic [31:0] gap;
		phase_t      nxt;
		mods = e.implicit_mods | e.explicit_mods;
		kp   = e.hid_page == KEY_PAGE;
		shf  = (mods & SHIFT_BITS) != 8'd0;
		nxt  = PH_INIT;
		r    = '0;
		state_changed = 1'b0;

		if (e.op == OP_TOGGLE) begin
			cap_enabled = !cap_enabled;
			reset_sentence();
			last_stamp = 32'd0;
		end else if (!cap_enabled) begin
			// Nothing at all happens while the feature is switched off.
		end else if (!e.pressed) begin
			if (mask_on && e.hid_page == mask_pg && e.key_code == mask_kc) begin
				mask_on = 1'b0;
				r.mask_shift_clear = 1'b1;
			end
		end else begin
			gap = e.time_ms - last_stamp;
			if (last_stamp != 32'd0 && gap > {16'd0, timeout_reg}) reset_sentence();
			last_stamp = e.time_ms;
			if (kp && e.key_code >= KC_MOD_FIRST && e.key_code <= KC_MOD_LAST) begin
				if (cur_phase == PH_PRIMED &&
				    (e.key_code == KC_LSHIFT || e.key_code == KC_RSHIFT)) begin
					opted = 1'b1;
					enter_phase(cur_phase);
				end
			end else if (kp && e.key_code == KC_BKSP) begin
				// Undo: pop the newest history entry, or fall back to init.
				if (undo_count == 0) begin
					enter_phase(PH_INIT);
				end else begin
					enter_phase(undo_hist[0]);
					for (int i = 0; i + 1 < undo_count; i++) undo_hist[i] = undo_hist[i + 1];
					undo_count--;
				end
			end else if ((mods & ~SHIFT_BITS) != 8'd0) begin
				reset_sentence();
			end else begin
				known = 1'b1;
				if (kp && e.key_code == KC_APOS) begin
					nxt = cur_phase;
				end else if (kp && e.key_code >= KC_A && e.key_code <= KC_Z) begin
					if (cur_phase == PH_PRIMED) begin
						if (opted && shf) begin
							r.mask_shift_set = 1'b1;
							mask_on = 1'b1;
							mask_pg = e.hid_page;
							mask_kc = e.key_code;
						end else if (!opted && !shf) begin
							r.add_shift = 1'b1;
						end
					end
					if (cur_phase == PH_END || cur_phase == PH_ABBR) nxt = PH_ABBR;
					else nxt = PH_WORD;
				end else if (kp && e.key_code == KC_SPACE) begin
					if (cur_phase == PH_END || cur_phase == PH_PRIMED) nxt = PH_PRIMED;
				end else if (kp && ((e.key_code == KC_DOT && !shf) ||
				                    (e.key_code == KC_SLASH && shf) ||
				                    (e.key_code == KC_1 && shf))) begin
					if (cur_phase == PH_WORD || cur_phase == PH_END) nxt = PH_END;
					else nxt = PH_ABBR;
				end else if (kp && e.key_code >= KC_1 && e.key_code <= KC_0) begin
					nxt = PH_WORD;
				end else begin
					known = 1'b0;
					reset_sentence();
				end
				if (known) begin
					// Save the current phase for undo; a full history drops its oldest.
					if (undo_count < HIST_DEPTH) undo_count++;
					for (int i = undo_count - 1; i > 0; i--) undo_hist[i] = undo_hist[i - 1];
					undo_hist[0] = cur_phase;
					enter_phase(nxt);
				end
			end
		end

		r.armed    = is_armed();
		r.disarmed = opted;
		r.notify   = state_changed;
		r.phase    = cur_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Calm stretches: while calm_left is nonzero neither side idles. One
	// stretch is forced early in the run and more come at random.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == 400) calm_left <= 250;
		else if (calm_left != 0) calm_left <= calm_left - 1;
		else if ($urandom_range(0, 599) == 0) calm_left <= 150;
	end

	// ------------------------------------------------------------------------
	// Driver. At each edge it first records a transfer that just happened and
	// predicts its result, then decides whether to present the next event.
	// A stalled event is held unchanged, and valid is set without looking at
	// the stall.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) expected_verdicts.push_back(capitalize_decision(drv));
			if (!in_valid || !in_stall) begin
				if (event_backlog.size() != 0 && (calm_left != 0 || $urandom_range(0, 99) >= 28)) begin
					drv      <= event_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Each result transfer is checked field by field against the
	// oldest prediction. The output stall is randomized independently.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {add_shift, mask_shift_set, mask_shift_clear, armed, disarmed, notify, phase};
				result_no++;
				if (expected_verdicts.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d arrived with no event outstanding", result_no);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.add_shift !== want.add_shift ||
					    got.mask_shift_set !== want.mask_shift_set ||
					    got.mask_shift_clear !== want.mask_shift_clear ||
					    got.armed !== want.armed ||
					    got.disarmed !== want.disarmed ||
					    got.notify !== want.notify ||
					    got.phase !== want.phase) begin
						errors++;
						if (errors <= 10)
							$display({"result %0d mismatch: expected add=%b mset=%b mclr=%b ",
							          "armed=%b disarmed=%b notify=%b phase=%0d, got add=%b ",
							          "mset=%b mclr=%b armed=%b disarmed=%b notify=%b phase=%0d"},
							         result_no, want.add_shift, want.mask_shift_set,
							         want.mask_shift_clear, want.armed, want.disarmed,
							         want.notify, want.phase, got.add_shift,
							         got.mask_shift_set, got.mask_shift_clear, got.armed,
							         got.disarmed, got.notify, got.phase);
					end
				end
			end
			out_stall <= (calm_left == 0) && ($urandom_range(0, 99) < 28);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus generation.
	// ------------------------------------------------------------------------
	logic [31:0] gen_ms = 32'd100;

	// Advances the typing clock by a fixed amount; used by the directed part.
	function automatic logic [31:0] later(logic [31:0] d);
		gen_ms = gen_ms + d;
		return gen_ms;
	endfunction

	// Random timestamps: mostly short gaps, sometimes gaps past the timeout,
	// sometimes a jump anywhere, and sometimes no timestamp at all.
	function automatic logic [31:0] next_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return 32'd0;
		if (r < 10) gen_ms = gen_ms + timeout_reg + $urandom_range(1, 3000);
		else if (r < 12) gen_ms = $urandom;
		else gen_ms = gen_ms + $urandom_range(0, (timeout_reg < 64) ? timeout_reg : 64);
		return gen_ms;
	endfunction

	// A keyboard-page event. Shift, when asked for, lands in either modifier
	// field as left, right or both shifts.
	function automatic evt_t key_evt(logic prs, logic [7:0] kc, logic shf, logic [31:0] stamp);
		evt_t       e;
		logic [7:0] sh;
		e            = '0;
		e.op         = OP_KEY;
		e.pressed    = prs;
		e.hid_page   = KEY_PAGE;
		e.key_code   = kc;
		e.time_ms    = stamp;
		if (shf) begin
			sh = ($urandom_range(0, 1) != 0) ? MOD_LSHIFT : MOD_RSHIFT;
			if ($urandom_range(0, 3) == 0) sh = SHIFT_BITS;
			if ($urandom_range(0, 1) != 0) e.implicit_mods = sh;
			else e.explicit_mods = sh;
		end
		return e;
	endfunction

	task automatic queue_event(evt_t e);
		event_backlog.push_back(e);
		n_items++;
	endtask

	// Press a key and usually release it right away.
	task automatic type_key(logic [7:0] kc, logic shf);
		queue_event(key_evt(1'b1, kc, shf, next_stamp()));
		if ($urandom_range(0, 99) < 60) queue_event(key_evt(1'b0, kc, shf, next_stamp()));
	endtask

	task automatic type_ending();
		case ($urandom_range(0, 2))
			0: type_key(KC_DOT, 1'b0);
			1: type_key(KC_SLASH, 1'b1);
			default: type_key(KC_1, 1'b1);
		endcase
	endtask

	// A well-formed sentence with random content: words, an ending, a space,
	// then a first letter that is capitalized, typed shifted, or opted out.
	task automatic type_sentence();
		int         nw;
		int         nl;
		int         r;
		logic [7:0] kc;
		logic [7:0] sk;
		nw = $urandom_range(1, 3);
		for (int i = 0; i < nw; i++) begin
			nl = $urandom_range(1, 6);
			for (int j = 0; j < nl; j++) begin
				r = $urandom_range(0, 99);
				if (r < 80) type_key(KC_A + $urandom_range(0, 25), $urandom_range(0, 9) == 0);
				else if (r < 88) type_key(KC_APOS, 1'b0);
				else if (r < 96) type_key(KC_1 + $urandom_range(0, 9), 1'b0);
				else type_key(KC_BKSP, 1'b0);
			end
			if (i < nw - 1) type_key(KC_SPACE, 1'b0);
		end
		type_ending();
		if ($urandom_range(0, 3) == 0) begin
			// Abbreviation: a letter straight after the ending, then another ending.
			type_key(KC_A + $urandom_range(0, 25), 1'b0);
			type_ending();
		end
		if ($urandom_range(0, 4) == 0) begin
			// Backspace burst, long enough at times to run past the undo depth.
			nl = $urandom_range(1, HIST_DEPTH + 2);
			for (int j = 0; j < nl; j++) type_key(KC_BKSP, 1'b0);
		end
		type_key(KC_SPACE, 1'b0);
		if ($urandom_range(0, 4) == 0) type_key(KC_SPACE, 1'b0);
		kc = KC_A + $urandom_range(0, 25);
		r  = $urandom_range(0, 99);
		if (r < 40) begin
			type_key(kc, 1'b0);
		end else if (r < 60) begin
			type_key(kc, 1'b1);
		end else begin
			sk = ($urandom_range(0, 1) != 0) ? KC_LSHIFT : KC_RSHIFT;
			queue_event(key_evt(1'b1, sk, 1'b1, next_stamp()));
			if (r < 85) begin
				// Shift still held at the letter: the mask goes on, then comes off
				// when the same letter is released.
				queue_event(key_evt(1'b1, kc, 1'b1, next_stamp()));
				if ($urandom_range(0, 3) == 0) type_key(KC_A + $urandom_range(0, 25), 1'b0);
				queue_event(key_evt(1'b0, kc, 1'b0, next_stamp()));
			end else begin
				type_key(kc, 1'b0);
			end
			queue_event(key_evt(1'b0, sk, 1'b0, next_stamp()));
		end
	endtask

	// Noise: arbitrary events, modifier keys, foreign pages, stray modifiers,
	// stray releases and enable toggles that come in pairs.
	task automatic type_noise();
		evt_t e;
		int   n;
		case ($urandom_range(0, 5))
			0: begin
				e.op            = OP_KEY;
				e.pressed       = $urandom_range(0, 1);
				e.hid_page      = $urandom;
				e.key_code      = $urandom;
				e.time_ms       = $urandom;
				e.implicit_mods = $urandom;
				e.explicit_mods = $urandom;
				queue_event(e);
			end
			1: type_key(KC_MOD_FIRST + $urandom_range(0, 7), $urandom_range(0, 1));
			2: begin
				e = key_evt(1'b1, $urandom, 1'b0, next_stamp());
				e.hid_page = $urandom_range(0, 6);
				queue_event(e);
			end
			3: begin
				e = key_evt(1'b1, KC_A + $urandom_range(0, 25), 1'b0, next_stamp());
				e.implicit_mods = $urandom & ~SHIFT_BITS;
				if (e.implicit_mods == 8'd0) e.explicit_mods = MOD_LCTRL;
				queue_event(e);
			end
			4: begin
				e    = '0;
				e.op = OP_TOGGLE;
				e.key_code = $urandom;
				queue_event(e);
				n = $urandom_range(0, 2);
				for (int i = 0; i < n; i++) type_key(KC_A + $urandom_range(0, 25), 1'b0);
				e.time_ms = $urandom;
				queue_event(e);
			end
			default: queue_event(key_evt(1'b0, $urandom, $urandom_range(0, 1), next_stamp()));
		endcase
	endtask

	// Waits until the block holds no event and owes no result, then lets the
	// pipeline settle. The check is made at the falling edge, when the driver
	// and the monitor have settled.
	task automatic wait_drained();
		while (event_backlog.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_timeout(logic [15:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		timeout_reg = v;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset, a directed walk through the sentence machine with
	// the reset timeout, then four random phases at different timeouts.
	// ------------------------------------------------------------------------
	initial begin
		evt_t        e;
		logic [15:0] setting;
		int          target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Toggle with every field at its maximum switches the feature off, a key
		// is then ignored, and a second toggle switches it back on.
		e = '1;
		queue_event(e);
		queue_event(key_evt(1'b1, KC_A, 1'b0, later(10)));
		e = '0;
		e.op = OP_TOGGLE;
		queue_event(e);
		// Backspace with an empty history falls back to init.
		queue_event(key_evt(1'b1, KC_BKSP, 1'b0, later(10)));
		// Word, period, space: the next letter gets shift added.
		queue_event(key_evt(1'b1, KC_A, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_DOT, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_SPACE, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_A + 1, 1'b0, later(10)));
		// Question mark and space, then shift pressed while primed disarms, and
		// a letter typed with shift still held is masked until released.
		queue_event(key_evt(1'b1, KC_SLASH, 1'b1, later(10)));
		queue_event(key_evt(1'b1, KC_SPACE, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_LSHIFT, 1'b1, later(10)));
		queue_event(key_evt(1'b1, KC_Z, 1'b1, later(10)));
		queue_event(key_evt(1'b0, KC_Z, 1'b1, later(10)));
		// Exclamation mark, then a letter right after it starts an abbreviation.
		queue_event(key_evt(1'b1, KC_1, 1'b1, later(10)));
		queue_event(key_evt(1'b1, KC_A + 3, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_APOS, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_0, 1'b0, later(10)));
		queue_event(key_evt(1'b1, KC_BKSP, 1'b0, later(10)));
		// A foreign usage page and a non-shift modifier both clear the sentence.
		e = key_evt(1'b1, KC_A, 1'b0, later(10));
		e.hid_page = 16'h0000;
		queue_event(e);
		e = key_evt(1'b1, KC_A, 1'b0, later(10));
		e.explicit_mods = MOD_LCTRL;
		queue_event(e);
		// A gap just past the timeout clears; a gap of exactly the timeout does not.
		queue_event(key_evt(1'b1, KC_A, 1'b0, later(TIMEOUT_RESET + 1)));
		queue_event(key_evt(1'b1, KC_A + 1, 1'b0, later(TIMEOUT_RESET)));
		// Unknown key on the all-ones page with no timestamp recorded.
		e = '0;
		e.pressed  = 1'b1;
		e.hid_page = 16'hFFFF;
		queue_event(e);
		// Highest key code with every modifier bit set.
		e = key_evt(1'b1, 8'hFF, 1'b0, later(10));
		e.implicit_mods = 8'hFF;
		e.explicit_mods = 8'hFF;
		queue_event(e);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: setting = 16'd0;
				1: setting = 16'hFFFF;
				2: setting = $urandom_range(1, 300);
				default: setting = TIMEOUT_RESET;
			endcase
			program_timeout(setting);
			// With the longest timeout, start just below the wrap of the
			// millisecond counter so that gaps are taken across it.
			if (p == 1) gen_ms = 32'hFFFF_F000;
			target = n_items + 120;
			while (n_items < target) begin
				if ($urandom_range(0, 99) < 70) type_sentence();
				else type_noise();
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("sentence_auto_capitalizer_top regression: pass");
		end else begin
			$display("sentence_auto_capitalizer_top regression: fail");
		end
		$finish;
	end

	// Watchdog against a hang: far beyond the slowest correct run.
	initial begin
		#3000000;
		$display("sentence_auto_capitalizer_top regression: fail");
		$finish;
	end

endmodule
